/* rtl/prf_pkg.sv */
`timescale 1ns / 1ps

package prf_pkg;

   localparam int MAX_ROW_BYTES_DEF = 8192;
   localparam int MAX_BPP_DEF       = 8;

   localparam int ROW_LEN_REG_W = 14;
   localparam int BPP_REG_W     = 4;
   localparam int CSR_DATA_W    = 14;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_ROW_LENGTH      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 1'b1;

   localparam logic [7:0] FILTER_TYPE_PAETH = 8'd4;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic       image_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_filter_type;
      logic       last;
   } rsp_payload_type;

endpackage

/* rtl/prf_stream_if.sv */
`timescale 1ns / 1ps

interface prf_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/prf_ram.sv */
`timescale 1ns / 1ps

module prf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = prf_pkg::MAX_ROW_BYTES_DEF,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write to one address return the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/prf_paeth_unit.sv */
`timescale 1ns / 1ps

module prf_paeth_unit (
   input  logic [7:0] raw_byte,
   input  logic [7:0] a_byte,
   input  logic [7:0] b_byte,
   input  logic [7:0] c_byte,
   output logic [7:0] filtered_byte
);

   logic signed [10:0] a_s;
   logic signed [10:0] b_s;
   logic signed [10:0] c_s;
   logic signed [10:0] p_s;
   logic signed [10:0] da;
   logic signed [10:0] db;
   logic signed [10:0] dc;
   logic [10:0]        pa;
   logic [10:0]        pb;
   logic [10:0]        pc;
   logic [7:0]         pred;

   always_comb begin
      a_s = signed'({3'b000, a_byte});
      b_s = signed'({3'b000, b_byte});
      c_s = signed'({3'b000, c_byte});
      p_s = a_s + b_s - c_s;
      da  = p_s - a_s;
      db  = p_s - b_s;
      dc  = p_s - c_s;
      pa  = (da < 0) ? unsigned'(-da) : unsigned'(da);
      pb  = (db < 0) ? unsigned'(-db) : unsigned'(db);
      pc  = (dc < 0) ? unsigned'(-dc) : unsigned'(dc);
      priority if (pa <= pb && pa <= pc) begin
         pred = a_byte;
      end else if (pb <= pc) begin
         pred = b_byte;
      end else begin
         pred = c_byte;
      end
      filtered_byte = raw_byte - pred;
   end

endmodule

/* rtl/paeth_row_filter_unit.sv */
`timescale 1ns / 1ps

// channel   role    handshake         beat payload
// req_chan  sink    valid / ready     pixel_byte[7:0], image_start
// rsp_chan  source  valid / ready     out_byte[7:0], is_filter_type, last
// csr       write   csr_wr_en         csr_index[0], csr_wr_data[13:0]
//
// One req beat per cycle while rsp_chan does not stall; a byte that opens a row
// holds req_ready low while its first beat goes out, since it gives two rsp beats
// (filter type 4, then the filtered byte) through one output register. An accepted
// req beat reaches rsp_valid through the line store read, then the predictor into the output register.
// Synchronous reset sets control and config and clears history; the line store and data
// registers are not cleared. A stall on rsp_chan holds a full stage and drops req_ready.

module paeth_row_filter_unit #(
   parameter int MAX_ROW_BYTES = prf_pkg::MAX_ROW_BYTES_DEF,
   parameter int MAX_BPP       = prf_pkg::MAX_BPP_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [prf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [prf_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   prf_stream_if.sink                       req_chan,
   prf_stream_if.source                     rsp_chan
);

   localparam int COL_W   = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int LEN_W   = $clog2(MAX_ROW_BYTES + 1);
   localparam int LCMP_W  = (LEN_W > prf_pkg::ROW_LEN_REG_W) ? LEN_W : prf_pkg::ROW_LEN_REG_W;
   localparam int BPP_W   = $clog2(MAX_BPP + 1);
   localparam int BCMP_W  = (BPP_W > prf_pkg::BPP_REG_W) ? BPP_W : prf_pkg::BPP_REG_W;
   localparam int HIST_W  = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;
   localparam int POS_W   = (LEN_W > BPP_W) ? LEN_W : BPP_W;

   logic [LEN_W-1:0]  eff_len_ff, eff_len_in;
   logic [BPP_W-1:0]  eff_bpp_ff, eff_bpp_in;
   logic [LCMP_W-1:0] len_wide;
   logic [BCMP_W-1:0] bpp_wide;

   logic [COL_W-1:0]  column_ff, column_in;
   logic              have_prev_ff, have_prev_in;
   logic [COL_W-1:0]  col_eff;
   logic              hpr_eff;
   logic [LEN_W-1:0]  col_next;
   logic              left_ok;
   logic              accept;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_phase_ff, s1_phase_in;
   logic              s1_first_ff;
   logic              s1_hpr_ff;
   logic              s1_left_ok_ff;
   logic [7:0]        s1_raw_ff;
   logic              s1_emit;
   logic              s1_type_beat;
   logic              s1_done;

   logic [7:0]        left_hist_ff [MAX_BPP];
   logic [7:0]        upleft_hist_ff [MAX_BPP];
   logic [BPP_W-1:0]  bpp_minus1;
   logic [HIST_W-1:0] hsel;
   logic [7:0]        up_rd;
   logic [7:0]        a_byte, b_byte, c_byte;
   logic [7:0]        filtered;

   logic                     out_valid_ff, out_valid_in;
   prf_pkg::rsp_payload_type out_ff, out_in;

   // config: saturate on write, a written zero becomes one
   always_comb begin
      eff_len_in = eff_len_ff;
      eff_bpp_in = eff_bpp_ff;
      len_wide   = LCMP_W'(csr_wr_data[prf_pkg::ROW_LEN_REG_W-1:0]);
      bpp_wide   = BCMP_W'(csr_wr_data[prf_pkg::BPP_REG_W-1:0]);
      if (csr_wr_en) begin
         unique case (csr_index)
            prf_pkg::REG_ROW_LENGTH: begin
               priority if (len_wide == '0) begin
                  eff_len_in = LEN_W'(1);
               end else if (len_wide > LCMP_W'(MAX_ROW_BYTES)) begin
                  eff_len_in = LEN_W'(MAX_ROW_BYTES);
               end else begin
                  eff_len_in = len_wide[LEN_W-1:0];
               end
            end
            prf_pkg::REG_BYTES_PER_PIXEL: begin
               priority if (bpp_wide == '0) begin
                  eff_bpp_in = BPP_W'(1);
               end else if (bpp_wide > BCMP_W'(MAX_BPP)) begin
                  eff_bpp_in = BPP_W'(MAX_BPP);
               end else begin
                  eff_bpp_in = bpp_wide[BPP_W-1:0];
               end
            end
            default: begin
               eff_len_in = eff_len_ff;
            end
         endcase
      end
   end

   // row position of the incoming beat
   always_comb begin
      priority if (req_chan.payload.image_start) begin
         col_eff = '0;
         hpr_eff = 1'b0;
      end else if (LEN_W'(column_ff) >= eff_len_ff) begin
         col_eff = '0;
         hpr_eff = 1'b1;
      end else begin
         col_eff = column_ff;
         hpr_eff = have_prev_ff;
      end
      col_next = LEN_W'(col_eff) + LEN_W'(1);
      if (col_next >= eff_len_ff) begin
         column_in    = '0;
         have_prev_in = 1'b1;
      end else begin
         column_in    = col_next[COL_W-1:0];
         have_prev_in = hpr_eff;
      end
      left_ok = POS_W'(col_eff) >= POS_W'(eff_bpp_ff);
   end

   assign s1_type_beat = s1_first_ff && !s1_phase_ff;
   assign s1_emit      = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign s1_done      = s1_emit && !s1_type_beat;
   assign req_chan.ready = !s1_valid_ff || s1_done;
   assign accept       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_phase_in = s1_phase_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_phase_in = 1'b0;
      end else if (s1_done) begin
         s1_valid_in = 1'b0;
      end else if (s1_emit) begin
         s1_phase_in = 1'b1;
      end
   end

   prf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_eff),
      .wr_data (req_chan.payload.pixel_byte),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (up_rd)
   );

   always_comb begin
      bpp_minus1 = eff_bpp_ff - BPP_W'(1);
      hsel       = bpp_minus1[HIST_W-1:0];
      a_byte     = s1_left_ok_ff ? left_hist_ff[hsel] : 8'd0;
      b_byte     = s1_hpr_ff ? up_rd : 8'd0;
      c_byte     = (s1_hpr_ff && s1_left_ok_ff) ? upleft_hist_ff[hsel] : 8'd0;
   end

   prf_paeth_unit u_paeth (
      .raw_byte      (s1_raw_ff),
      .a_byte        (a_byte),
      .b_byte        (b_byte),
      .c_byte        (c_byte),
      .filtered_byte (filtered)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (s1_emit) begin
         out_valid_in = 1'b1;
         if (s1_type_beat) begin
            out_in.out_byte       = prf_pkg::FILTER_TYPE_PAETH;
            out_in.is_filter_type = 1'b1;
            out_in.last           = 1'b0;
         end else begin
            out_in.out_byte       = filtered;
            out_in.is_filter_type = 1'b0;
            out_in.last           = 1'b1;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_len_ff   <= LEN_W'(1);
         eff_bpp_ff   <= BPP_W'(1);
         column_ff    <= '0;
         have_prev_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_phase_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         eff_len_ff   <= eff_len_in;
         eff_bpp_ff   <= eff_bpp_in;
         s1_valid_ff  <= s1_valid_in;
         s1_phase_ff  <= s1_phase_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            column_ff    <= column_in;
            have_prev_ff <= have_prev_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (accept) begin
         s1_first_ff   <= (col_eff == '0);
         s1_hpr_ff     <= hpr_eff;
         s1_left_ok_ff <= left_ok;
         s1_raw_ff     <= req_chan.payload.pixel_byte;
      end
   end

   // shift histories when the stage retires its byte
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_BPP; k++) begin
            left_hist_ff[k]   <= 8'd0;
            upleft_hist_ff[k] <= 8'd0;
         end
      end else if (s1_done) begin
         left_hist_ff[0]   <= s1_raw_ff;
         upleft_hist_ff[0] <= b_byte;
         for (int k = 1; k < MAX_BPP; k++) begin
            left_hist_ff[k]   <= left_hist_ff[k-1];
            upleft_hist_ff[k] <= upleft_hist_ff[k-1];
         end
      end
   end

endmodule

/* rtl/prf_checker.sv */
`timescale 1ns / 1ps

module prf_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input prf_pkg::rsp_payload_type rsp_payload
);

   // filter type beat carries code 4 and never closes the input's results
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_filter_type |->
         rsp_payload.out_byte == prf_pkg::FILTER_TYPE_PAETH && !rsp_payload.last)
      else $error("filter type beat malformed");

   // the filtered byte follows a taken filter type beat at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.is_filter_type |=>
         rsp_valid && !rsp_payload.is_filter_type && rsp_payload.last)
      else $error("filtered byte missing after filter type beat");

   // hold a stalled rsp beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled rsp beat changed");

   // show an accepted req beat on rsp
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("rsp beat late after req beat");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind paeth_row_filter_unit prf_checker u_prf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
